@@ src/nlb_pkg.sv @@
// Shared types and constants for the pairwise neighbour list builder.
// No dependencies.
package nlb_pkg;

	localparam int MAX_ATOMS_DEF = 64;
	localparam int IDX_W         = 6;
	localparam int CNT_W         = 7;
	localparam int LEN_W         = 31;
	localparam int OFF_W         = 12;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int PIPE_DEPTH    = 6;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RADIUS = 2'd1;
	localparam logic [1:0] ST_CENTER = 2'd2;

	localparam logic [OFF_W-1:0] OFFSET_CAP = {OFF_W{1'b1}};
	localparam logic [LEN_W-1:0] BOX_RESET  = 31'd1048576;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pos_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
	} cand_t;

endpackage

@@ src/nlb_cell.sv @@
// One position cell of the rotating atom chain.
// Depends on nlb_pkg.
module nlb_cell (
	input  logic         clk,
	input  logic         load_en,
	input  nlb_pkg::pos_t load_pos,
	input  logic         shift_en,
	input  nlb_pkg::pos_t shift_in,
	output nlb_pkg::pos_t pos
);
	import nlb_pkg::*;

	pos_t pos_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			pos_q <= load_pos;
		end else if (shift_en) begin
			pos_q <= shift_in;
		end
	end

	assign pos = pos_q;
endmodule

@@ src/nlb_dist.sv @@
// Minimum-image squared distance pipeline and radius test, six stages.
// Depends on nlb_pkg.
module nlb_dist (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  nlb_pkg::cand_t            cand_in,
	input  nlb_pkg::pos_t             cand_pos,
	input  nlb_pkg::pos_t             cent_pos,
	input  logic [nlb_pkg::LEN_W-1:0] len_x,
	input  logic [nlb_pkg::LEN_W-1:0] len_y,
	input  logic [nlb_pkg::LEN_W-1:0] len_z,
	input  logic [61:0]               r2,
	output nlb_pkg::cand_t            hit
);
	import nlb_pkg::*;

	logic signed [31:0]      ca [3];
	logic signed [31:0]      ce [3];
	logic [LEN_W-1:0]        len [3];
	logic signed [32:0]      d_s1 [3];
	logic signed [33:0]      w_s2 [3];
	logic signed [33:0]      w_c [3];
	logic [31:0]             m_s3 [3];
	logic [63:0]             sq_s4 [3];
	logic [65:0]             sum_s5;
	cand_t                   t_s1, t_s2, t_s3, t_s4, t_s5, hit_s6;

	assign ca[0] = cand_pos.x;
	assign ca[1] = cand_pos.y;
	assign ca[2] = cand_pos.z;
	assign ce[0] = cent_pos.x;
	assign ce[1] = cent_pos.y;
	assign ce[2] = cent_pos.z;
	assign len[0] = len_x;
	assign len[1] = len_y;
	assign len[2] = len_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [33:0] two;
			logic signed [33:0] lz;
			logic signed [33:0] dw;
			two = $signed({d_s1[k], 1'b0});
			lz  = $signed({3'b000, len[k]});
			dw  = $signed({d_s1[k][32], d_s1[k]});
			if (two > lz) begin
				w_c[k] = dw - lz;
			end else if (two < -lz) begin
				w_c[k] = dw + lz;
			end else begin
				w_c[k] = dw;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]  <= $signed({ca[k][31], ca[k]}) - $signed({ce[k][31], ce[k]});
				w_s2[k]  <= w_c[k];
				m_s3[k]  <= w_s2[k][33] ? 32'(-w_s2[k]) : w_s2[k][31:0];
				sq_s4[k] <= m_s3[k] * m_s3[k];
			end
			sum_s5 <= 66'(sq_s4[0]) + 66'(sq_s4[1]) + 66'(sq_s4[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1   <= '0;
			t_s2   <= '0;
			t_s3   <= '0;
			t_s4   <= '0;
			t_s5   <= '0;
			hit_s6 <= '0;
		end else if (en) begin
			t_s1         <= cand_in;
			t_s2         <= t_s1;
			t_s3         <= t_s2;
			t_s4         <= t_s3;
			t_s5         <= t_s4;
			hit_s6.index <= t_s5.index;
			hit_s6.valid <= t_s5.valid && (sum_s5 < {4'b0000, r2});
		end
	end

	assign hit = hit_s6;
endmodule

@@ src/pairwise_neighbor_list_builder.sv @@
// Top level: configuration, atom chain, sequencer and result register.
// Depends on nlb_pkg, nlb_cell, nlb_dist.
//
// channel  | handshake                   | payload
// item     | item_valid / item_stall     | kind, atom_index, pos_x, pos_y, pos_z
// result   | result_valid / result_stall | neighbor_valid .. status
// config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A build rotates the chain once to pick up the centre and once to stream
// candidates.
// Error builds present their result in the cycle after acceptance.
// Reset clears control and offset and restores the configuration defaults.
// A stalled result freezes the whole datapath until it is taken.
module pairwise_neighbor_list_builder #(
	parameter int MAX_ATOMS = nlb_pkg::MAX_ATOMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           kind,
	input  logic [nlb_pkg::IDX_W-1:0]      atom_index,
	input  logic signed [31:0]             pos_x,
	input  logic signed [31:0]             pos_y,
	input  logic signed [31:0]             pos_z,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           neighbor_valid,
	output logic [nlb_pkg::IDX_W-1:0]      neighbor_index,
	output logic [nlb_pkg::OFF_W-1:0]      row_offset,
	output logic                           last,
	output logic [1:0]                     status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nlb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nlb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nlb_pkg::*;

	localparam int CW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam logic [CW-1:0]    CNT_LAST = CW'(MAX_ATOMS - 1);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ATOMS);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_STREAM = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_ROWEND = 5'b10000
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  box_x_q, box_y_q, box_z_q, radius_q;
	logic [CNT_W-1:0]  active_q;
	logic [61:0]       r2_q;
	logic [CW-1:0]     cnt_q;
	logic [2:0]        drain_q;
	logic [IDX_W-1:0]  center_q;
	pos_t              cent_q;
	logic [OFF_W-1:0]  offset_q;
	pos_t              cells [MAX_ATOMS];
	pos_t              load_pos;
	cand_t             inject, hit;
	logic              adv, item_acc, load_acc, build_acc, shift_en;
	logic              radius_bad, center_bad;
	logic [CNT_W-1:0]  count;
	logic [31:0]       r2x;

	assign adv       = !(result_valid && result_stall);
	assign item_stall = (state_q != S_IDLE) || !adv;
	assign item_acc  = item_valid && !item_stall;
	assign load_acc  = item_acc && !kind;
	assign build_acc = item_acc && kind;
	assign cfg_ready = 1'b1;

	assign count      = (active_q > MAX_CNT) ? MAX_CNT : active_q;
	assign r2x        = {radius_q, 1'b0};
	assign radius_bad = (r2x > {1'b0, box_x_q}) || (r2x > {1'b0, box_y_q}) ||
	                    (r2x > {1'b0, box_z_q});
	assign center_bad = {1'b0, atom_index} >= count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q  <= BOX_RESET;
			box_y_q  <= BOX_RESET;
			box_z_q  <= BOX_RESET;
			radius_q <= '0;
			active_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOX_X:  box_x_q  <= cfg_data[LEN_W-1:0];
				REG_BOX_Y:  box_y_q  <= cfg_data[LEN_W-1:0];
				REG_BOX_Z:  box_z_q  <= cfg_data[LEN_W-1:0];
				REG_RADIUS: radius_q <= cfg_data[LEN_W-1:0];
				REG_ACTIVE: active_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= radius_q * radius_q;
	end

	assign load_pos.x = pos_x;
	assign load_pos.y = pos_y;
	assign load_pos.z = pos_z;
	assign shift_en   = adv && ((state_q == S_SCAN) || (state_q == S_STREAM));

	for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
		nlb_cell u_cell (
			.clk      (clk),
			.load_en  (load_acc && (atom_index == IDX_W'(i))),
			.load_pos (load_pos),
			.shift_en (shift_en),
			.shift_in (cells[(i + 1) % MAX_ATOMS]),
			.pos      (cells[i])
		);
	end

	assign inject.valid = (state_q == S_STREAM) && (CNT_W'(cnt_q) < count) &&
	                      (IDX_W'(cnt_q) != center_q);
	assign inject.index = IDX_W'(cnt_q);

	nlb_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.cand_in  (inject),
		.cand_pos (cells[0]),
		.cent_pos (cent_q),
		.len_x    (box_x_q),
		.len_y    (box_y_q),
		.len_z    (box_z_q),
		.r2       (r2_q),
		.hit      (hit)
	);

	always_ff @(posedge clk) begin
		if (build_acc) begin
			center_q <= atom_index;
		end
		if (adv && (state_q == S_SCAN) && (IDX_W'(cnt_q) == center_q)) begin
			cent_q <= cells[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			drain_q <= '0;
		end else if (adv) begin
			case (state_q)
				S_IDLE: begin
					if (build_acc && !radius_bad && !center_bad) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_STREAM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_STREAM: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						drain_q <= '0;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (drain_q == 3'(PIPE_DEPTH)) begin
						state_q <= S_ROWEND;
					end else begin
						drain_q <= drain_q + 1'b1;
					end
				end
				S_ROWEND: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (load_acc) begin
			offset_q <= '0;
		end else if (adv && hit.valid && (offset_q != OFFSET_CAP)) begin
			offset_q <= offset_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= (state_q == S_ROWEND) || (build_acc && (radius_bad || center_bad)) ||
			                hit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neighbor_valid <= 1'b0;
			neighbor_index <= '0;
			row_offset     <= '0;
			last           <= 1'b0;
			status         <= ST_OK;
			if (state_q == S_ROWEND) begin
				row_offset <= offset_q;
				last       <= 1'b1;
			end else if (build_acc && radius_bad) begin
				last   <= 1'b1;
				status <= ST_RADIUS;
			end else if (build_acc && center_bad) begin
				last   <= 1'b1;
				status <= ST_CENTER;
			end else begin
				neighbor_valid <= 1'b1;
				neighbor_index <= hit.index;
			end
		end
	end
endmodule
